/* rtl/source_byte_tokenizer_core_defines.svh */
// Assertion macros for the byte tokenizer checker.
`ifndef SOURCE_BYTE_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SRCBT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("srcbt: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define SRCBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("srcbt: next-cycle check failed");

// Check that holds in the cycle after reset is applied.
`define SRCBT_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("srcbt: reset check failed");

`endif

/* rtl/srcbt_pkg.sv */
//------------------------------------------------------------------------------
// srcbt_pkg
// Types, constants and byte classification for the source byte tokenizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package srcbt_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int MAX_TOKEN_LEN = 255;
    localparam int POS_W         = 24;
    localparam int LEN_W         = 8;
    localparam int LEN_OUT_MAX   = 255;
    localparam int OPEN_LEN_W    = $clog2(MAX_TOKEN_LEN + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [OPEN_LEN_W-1:0]  open_len_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [7:0]             char_t;
    typedef logic [QUEUE_AW-1:0]    qptr_t;
    typedef logic [QUEUE_AW:0]      qcount_t;

    localparam offset_t   OFFSET_MAX   = '1;
    localparam offset_t   LINE_FIRST   = offset_t'(1);
    localparam open_len_t OPEN_LEN_MAX = OPEN_LEN_W'(MAX_TOKEN_LEN);
    localparam qcount_t   QUEUE_FULL   = qcount_t'(QUEUE_DEPTH);
    localparam qptr_t     QUEUE_LAST   = qptr_t'(QUEUE_DEPTH - 1);

    localparam char_t CH_NUL     = 8'h00;
    localparam char_t CH_TAB     = 8'h09;
    localparam char_t CH_LF      = 8'h0A;
    localparam char_t CH_CR      = 8'h0D;
    localparam char_t CH_SPACE   = 8'h20;
    localparam char_t CH_0       = 8'h30;
    localparam char_t CH_9       = 8'h39;
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_Z = 8'h5A;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_Z = 8'h7A;

    typedef enum logic [3:0] {
        KIND_END      = 4'd0,
        KIND_IDENT    = 4'd1,
        KIND_INT      = 4'd2,
        KIND_PLUS     = 4'd3,
        KIND_MINUS    = 4'd4,
        KIND_STAR     = 4'd5,
        KIND_SLASH    = 4'd6,
        KIND_EQUAL    = 4'd7,
        KIND_LPAREN   = 4'd8,
        KIND_RPAREN   = 4'd9,
        KIND_LBRACE   = 4'd10,
        KIND_RBRACE   = 4'd11,
        KIND_LBRACKET = 4'd12,
        KIND_RBRACKET = 4'd13,
        KIND_COMMA    = 4'd14,
        KIND_UNKNOWN  = 4'd15
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT
    } scan_mode_t;

    // One queue entry: the tokens caused by one byte.
    typedef struct packed {
        logic  has_close;
        kind_t close_kind;
        pos_t  close_start;
        len_t  close_len;
        logic  has_own;
        kind_t own_kind;
        pos_t  own_start;
        len_t  own_len;
        char_t own_byte;
        pos_t  line;
    } tok_rec_t;

    function automatic logic is_letter(input char_t b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
    endfunction

    function automatic logic is_digit(input char_t b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic logic is_space(input char_t b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic kind_t single_kind(input char_t b);
        kind_t k;
        unique case (b)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3D:   k = KIND_EQUAL;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h5B:   k = KIND_LBRACKET;
            8'h5D:   k = KIND_RBRACKET;
            8'h2C:   k = KIND_COMMA;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic offset_t sat_inc(input offset_t v);
        return (v == OFFSET_MAX) ? OFFSET_MAX : v + offset_t'(1);
    endfunction

    function automatic pos_t to_pos(input offset_t v);
        return POS_W'(v);
    endfunction

    function automatic len_t to_len(input open_len_t v);
        return (32'(v) > LEN_OUT_MAX) ? '1 : LEN_W'(v);
    endfunction

endpackage

/* rtl/srcbt_queue.sv */
//------------------------------------------------------------------------------
// srcbt_queue
// Short register FIFO of token records between scanner and output stage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcbt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  srcbt_pkg::tok_rec_t push_rec,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output srcbt_pkg::tok_rec_t head_rec
);

    srcbt_pkg::tok_rec_t mem_reg [srcbt_pkg::QUEUE_DEPTH];
    srcbt_pkg::qptr_t    wr_ptr_reg, wr_ptr_next;
    srcbt_pkg::qptr_t    rd_ptr_reg, rd_ptr_next;
    srcbt_pkg::qcount_t  count_reg,  count_next;

    assign full       = (count_reg == srcbt_pkg::QUEUE_FULL);
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == srcbt_pkg::QUEUE_LAST) ? '0
                        : wr_ptr_reg + srcbt_pkg::qptr_t'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == srcbt_pkg::QUEUE_LAST) ? '0
                        : rd_ptr_reg + srcbt_pkg::qptr_t'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + srcbt_pkg::qcount_t'(1);
        end else if (pop && !push) begin
            count_next = count_reg - srcbt_pkg::qcount_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* rtl/srcbt_front.sv */
//------------------------------------------------------------------------------
// srcbt_front
// Byte scanner: classifies each byte, tracks open tokens, offset and line.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcbt_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  srcbt_pkg::char_t      s_char_byte,
    input  logic                  q_full,
    output logic                  push,
    output srcbt_pkg::tok_rec_t   push_rec
);

    srcbt_pkg::scan_mode_t mode_reg,       mode_next;
    srcbt_pkg::offset_t    offset_reg,     offset_next;
    srcbt_pkg::offset_t    line_reg,       line_next;
    srcbt_pkg::offset_t    open_start_reg, open_start_next;
    srcbt_pkg::open_len_t  open_len_reg,   open_len_next;

    logic accept;
    logic letter, digit, space, extend;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign letter  = srcbt_pkg::is_letter(s_char_byte);
    assign digit   = srcbt_pkg::is_digit(s_char_byte);
    assign space   = srcbt_pkg::is_space(s_char_byte);
    assign extend  = (mode_reg == srcbt_pkg::MODE_IDENT && (letter || digit)) ||
                     (mode_reg == srcbt_pkg::MODE_INT && digit);

    // Next state
    always_comb begin
        mode_next       = mode_reg;
        offset_next     = offset_reg;
        line_next       = line_reg;
        open_start_next = open_start_reg;
        open_len_next   = open_len_reg;
        if (accept) begin
            if (extend) begin
                if (open_len_reg < srcbt_pkg::OPEN_LEN_MAX) begin
                    open_len_next = open_len_reg + srcbt_pkg::open_len_t'(1);
                end
                offset_next = srcbt_pkg::sat_inc(offset_reg);
            end else begin
                mode_next       = srcbt_pkg::MODE_IDLE;
                open_start_next = '0;
                open_len_next   = '0;
                priority if (s_char_byte == srcbt_pkg::CH_NUL) begin
                    offset_next = '0;
                    line_next   = srcbt_pkg::LINE_FIRST;
                end else if (space) begin
                    if (s_char_byte == srcbt_pkg::CH_LF) begin
                        line_next = srcbt_pkg::sat_inc(line_reg);
                    end
                    offset_next = srcbt_pkg::sat_inc(offset_reg);
                end else if (letter || digit) begin
                    mode_next       = letter ? srcbt_pkg::MODE_IDENT : srcbt_pkg::MODE_INT;
                    open_start_next = offset_reg;
                    open_len_next   = srcbt_pkg::open_len_t'(1);
                    offset_next     = srcbt_pkg::sat_inc(offset_reg);
                end else begin
                    offset_next = srcbt_pkg::sat_inc(offset_reg);
                end
            end
        end
    end

    // Outputs
    always_comb begin
        push_rec             = '0;
        push_rec.has_close   = (mode_reg != srcbt_pkg::MODE_IDLE);
        push_rec.close_kind  = (mode_reg == srcbt_pkg::MODE_IDENT) ? srcbt_pkg::KIND_IDENT
                                                                    : srcbt_pkg::KIND_INT;
        push_rec.close_start = srcbt_pkg::to_pos(open_start_reg);
        push_rec.close_len   = srcbt_pkg::to_len(open_len_reg);
        push_rec.own_start   = srcbt_pkg::to_pos(offset_reg);
        push_rec.line        = srcbt_pkg::to_pos(line_reg);
        push_rec.own_kind    = srcbt_pkg::KIND_END;
        if (s_char_byte == srcbt_pkg::CH_NUL) begin
            push_rec.has_own = 1'b1;
        end else if (!space && !letter && !digit) begin
            push_rec.has_own  = 1'b1;
            push_rec.own_kind = srcbt_pkg::single_kind(s_char_byte);
            push_rec.own_len  = srcbt_pkg::len_t'(1);
            push_rec.own_byte = s_char_byte;
        end
        push = accept && !extend && (push_rec.has_close || push_rec.has_own);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= srcbt_pkg::MODE_IDLE;
            offset_reg     <= '0;
            line_reg       <= srcbt_pkg::LINE_FIRST;
            open_start_reg <= '0;
            open_len_reg   <= '0;
        end else begin
            mode_reg       <= mode_next;
            offset_reg     <= offset_next;
            line_reg       <= line_next;
            open_start_reg <= open_start_next;
            open_len_reg   <= open_len_next;
        end
    end

endmodule

/* rtl/srcbt_back.sv */
//------------------------------------------------------------------------------
// srcbt_back
// Output stage: holds one record and issues its one or two tokens.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcbt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  srcbt_pkg::tok_rec_t head_rec,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_token_kind,
    output srcbt_pkg::pos_t     m_token_start,
    output srcbt_pkg::len_t     m_token_length,
    output srcbt_pkg::pos_t     m_token_line,
    output srcbt_pkg::char_t    m_token_byte,
    output logic                m_last_of_run
);

    srcbt_pkg::tok_rec_t rec_reg;
    logic                valid_reg,  valid_next;
    logic                second_reg, second_next;
    logic                show_close, done;

    assign show_close = rec_reg.has_close && !second_reg;
    assign done       = valid_reg && m_ready && m_last_of_run;
    assign pop        = head_valid && (!valid_reg || done);

    always_comb begin
        valid_next  = valid_reg;
        second_next = second_reg;
        if (pop) begin
            valid_next  = 1'b1;
            second_next = 1'b0;
        end else if (done) begin
            valid_next  = 1'b0;
            second_next = 1'b0;
        end else if (valid_reg && m_ready) begin
            second_next = 1'b1;
        end
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = show_close ? rec_reg.close_kind  : rec_reg.own_kind;
    assign m_token_start  = show_close ? rec_reg.close_start : rec_reg.own_start;
    assign m_token_length = show_close ? rec_reg.close_len   : rec_reg.own_len;
    assign m_token_byte   = show_close ? '0                  : rec_reg.own_byte;
    assign m_token_line   = rec_reg.line;
    assign m_last_of_run  = !show_close || !rec_reg.has_own;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= head_rec;
        end
    end

endmodule

/* rtl/source_byte_tokenizer_core.sv */
//------------------------------------------------------------------------------
// source_byte_tokenizer_core
// Byte-at-a-time lexer: identifiers, integers, operators, unknown and end.
//
//   Channel | Ports | Carries
//   --------+-------+------------------------------------------------
//   input   | s_*   | one source byte per transaction
//   output  | m_*   | one token per transaction (kind/start/len/line/byte)
//
// Takes one byte per cycle unless the queue is full; each byte is scanned in
// the cycle it is accepted. Tokens leave at one per cycle from the output
// stage unless m_ready is low, so a byte that closes a token and makes its own
// yields two tokens. A four-entry queue between the stages absorbs that and
// output stalls. Synchronous active-low reset; no clearing pass.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_byte_tokenizer_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_token_kind,
    output logic [23:0]         m_token_start,
    output logic [7:0]          m_token_length,
    output logic [23:0]         m_token_line,
    output logic [7:0]          m_token_byte,
    output logic                m_last_of_run
);

    logic                q_full, q_push, q_pop, q_head_valid;
    srcbt_pkg::tok_rec_t q_push_rec, q_head_rec;

    srcbt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .q_full      (q_full),
        .push        (q_push),
        .push_rec    (q_push_rec)
    );

    srcbt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_rec   (q_push_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_rec   (q_head_rec)
    );

    srcbt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (q_head_valid),
        .head_rec       (q_head_rec),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_token_line   (m_token_line),
        .m_token_byte   (m_token_byte),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

/* rtl/srcbt_checker.sv */
//------------------------------------------------------------------------------
// srcbt_checker
// Port-level checks for the source byte tokenizer, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "source_byte_tokenizer_core_defines.svh"

module srcbt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_token_kind,
    input logic [7:0]  m_token_length,
    input logic [23:0] m_token_line,
    input logic [7:0]  m_token_byte,
    input logic        m_last_of_run
);

    logic is_end, is_word, is_single;
    logic end_shape, word_shape, single_shape;

    assign is_end    = (m_token_kind == srcbt_pkg::KIND_END);
    assign is_word   = (m_token_kind == srcbt_pkg::KIND_IDENT) ||
                       (m_token_kind == srcbt_pkg::KIND_INT);
    assign is_single = !is_end && !is_word;

    assign end_shape    = m_last_of_run && m_token_length == 8'd0 && m_token_byte == 8'd0;
    assign word_shape   = m_token_byte == 8'd0 && m_token_length != 8'd0 &&
                          m_token_line != 24'd0;
    assign single_shape = m_last_of_run && m_token_length == 8'd1;

    `SRCBT_ASSERT_RESET(a_reset_idle, !m_valid)
    `SRCBT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_token_kind))
    `SRCBT_ASSERT_SAME(a_end_last, m_valid && is_end, end_shape)
    `SRCBT_ASSERT_SAME(a_word_shape, m_valid && is_word, word_shape)
    `SRCBT_ASSERT_SAME(a_single_shape, m_valid && is_single, single_shape)

endmodule

bind source_byte_tokenizer_core srcbt_checker u_srcbt_checker (.*);
